// File: sv/bca_pkg.sv
// bca_pkg: shared types and constants for the bloom counter array.
// Field widths, op and status codes, config register indexes, ALU result struct.
// No dependencies.
package bca_pkg;

  localparam int OP_W      = 3;
  localparam int IDX_W     = 13;
  localparam int AMT_W     = 8;
  localparam int WM_W      = 2;
  localparam int ITEMS_W   = 14;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 14;
  localparam int ST_W      = 2;

  localparam logic [3:0] NIB_MAX  = 4'd15;
  // byte add flags a sum at or above the 8-bit max
  localparam logic [8:0] BYTE_TOP = 9'd255;
  localparam logic [WM_W-1:0] WM_NIBBLE = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_SET  = 3'd0,
    OP_TEST = 3'd1,
    OP_NINC = 3'd2,
    OP_NDEC = 3'd3,
    OP_BADD = 3'd4,
    OP_BSUB = 3'd5
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_OVF   = 2'd2,
    ST_MODE  = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH_MODE = 1'b0,
    CFG_ITEMS      = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic       answer;
    status_t    status;
    logic       we;
    logic [7:0] wdata;
  } alu_res_t;

endpackage

// File: sv/bca_if.sv
// bca_if: valid/ready channel interfaces for operation and result beats.
// Depends on bca_pkg for field widths.
interface bca_in_if;
  logic                        valid;
  logic                        ready;
  logic [bca_pkg::OP_W-1:0]    op;
  logic [bca_pkg::IDX_W-1:0]   index;
  logic [bca_pkg::AMT_W-1:0]   amount;

  modport source (output valid, output op, output index, output amount, input ready);
  modport sink   (input valid, input op, input index, input amount, output ready);
endinterface

interface bca_out_if;
  logic                        valid;
  logic                        ready;
  logic                        answer;
  logic [bca_pkg::ST_W-1:0]    status;

  modport source (output valid, output answer, output status, input ready);
  modport sink   (input valid, input answer, input status, output ready);
endinterface

// File: sv/bloom_counter_array.sv
// bloom_counter_array: counting Bloom filter cell array, top level.
// Pipeline: the accepting edge launches the memory read into stage 1; when stage 1 advances,
// the cell byte is modified and written back and the output register loads the result beat.
// Throughput: one beat per cycle unless out_ch stalls, set by the cell memory's single read and write port.
// Reset: config returns to width_mode 2, items_in_use 2048; the memory is then zeroed
// one byte per cycle over all BYTE_DEPTH bytes, with in_ch.ready low (config writes still taken).
module bloom_counter_array #(
  parameter int BYTE_DEPTH = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [bca_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bca_pkg::CFG_DAT_W-1:0]    cfg_wdata,
  bca_in_if.sink                           in_ch,
  bca_out_if.source                        out_ch
);

  localparam int AW = (BYTE_DEPTH > 1) ? $clog2(BYTE_DEPTH) : 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [bca_pkg::WM_W-1:0]    wm_r;
  logic [bca_pkg::ITEMS_W-1:0] items_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wm_r    <= 2'd2;
      items_r <= 14'd2048;
    end else if (cfg_we) begin
      unique case (bca_pkg::cfg_idx_t'(cfg_index))
        bca_pkg::CFG_WIDTH_MODE: wm_r    <= cfg_wdata[bca_pkg::WM_W-1:0];
        bca_pkg::CFG_ITEMS:      items_r <= cfg_wdata[bca_pkg::ITEMS_W-1:0];
      endcase
    end
  end

  // bytes in use = ceil(items << mode / 8); the cap at BYTE_DEPTH is a
  // separate compare below so no width depends on the depth.
  logic [16:0] bits_w;
  logic [17:0] bytes_w;
  always_comb begin
    bits_w  = 17'(items_r) << wm_r;
    bytes_w = (18'(bits_w) + 18'd7) >> 3;
  end

  // ---------------------------------------------------------------------------
  // Clearing sweep after reset
  // ---------------------------------------------------------------------------
  logic          clr_r;
  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(BYTE_DEPTH - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Issue: decode byte position, range / mode check, launch memory read
  // ---------------------------------------------------------------------------
  logic                          s1_valid_r;
  logic                          s1_adv;
  logic                          in_acc;
  logic [bca_pkg::IDX_W-1:0]     pos0;
  logic                          pos_ok;
  bca_pkg::status_t              pre_st0;
  logic [AW-1:0]                 addr0;

  assign in_ch.ready = !clr_r && (!s1_valid_r || s1_adv);
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    priority case (bca_pkg::op_t'(in_ch.op))
      bca_pkg::OP_SET, bca_pkg::OP_TEST:
        pos0 = {3'd0, in_ch.index[bca_pkg::IDX_W-1:3]};
      bca_pkg::OP_NINC, bca_pkg::OP_NDEC:
        pos0 = {1'b0, in_ch.index[bca_pkg::IDX_W-1:1]};
      default:
        pos0 = in_ch.index;
    endcase
    pos_ok = (18'(pos0) < bytes_w) && (18'(pos0) < 18'(BYTE_DEPTH));
    addr0  = AW'(pos0);

    pre_st0 = bca_pkg::ST_OK;
    priority case (bca_pkg::op_t'(in_ch.op))
      bca_pkg::OP_NINC, bca_pkg::OP_NDEC: begin
        if (wm_r != bca_pkg::WM_NIBBLE) begin
          pre_st0 = bca_pkg::ST_MODE;   // mode check wins over range
        end else if (!pos_ok) begin
          pre_st0 = bca_pkg::ST_RANGE;
        end
      end
      bca_pkg::OP_SET, bca_pkg::OP_TEST, bca_pkg::OP_BADD, bca_pkg::OP_BSUB: begin
        if (!pos_ok) begin
          pre_st0 = bca_pkg::ST_RANGE;
        end
      end
      default: pre_st0 = bca_pkg::ST_OK;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stage 1: read data arrives, modify, write back, load output register
  // ---------------------------------------------------------------------------
  logic [bca_pkg::OP_W-1:0]  s1_op_r;
  logic [2:0]                s1_sel_r;
  logic [bca_pkg::AMT_W-1:0] s1_amt_r;
  bca_pkg::status_t          s1_pre_r;
  logic [AW-1:0]             s1_addr_r;
  logic                      fwd_r;
  logic [7:0]                fwd_data_r;
  logic [7:0]                rd_data;
  logic [7:0]                s1_data;
  bca_pkg::alu_res_t         res;
  logic                      out_valid_r;
  logic                      out_answer_r;
  logic [bca_pkg::ST_W-1:0]  out_status_r;

  assign s1_adv  = s1_valid_r && (!out_valid_r || out_ch.ready);
  // back-to-back beats on one byte: the memory read saw the old value
  assign s1_data = fwd_r ? fwd_data_r : rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
        fwd_r      <= s1_adv && res.we && (addr0 == s1_addr_r);
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
        fwd_r      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r    <= in_ch.op;
      s1_sel_r   <= in_ch.index[2:0];
      s1_amt_r   <= in_ch.amount;
      s1_pre_r   <= pre_st0;
      s1_addr_r  <= addr0;
      fwd_data_r <= res.wdata;
    end
  end

  bca_alu u_alu (
    .op     (s1_op_r),
    .sel    (s1_sel_r),
    .amount (s1_amt_r),
    .data   (s1_data),
    .pre_st (s1_pre_r),
    .res    (res)
  );

  bca_mem #(
    .DEPTH (BYTE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (clr_r || (s1_adv && res.we)),
    .waddr (clr_r ? clr_addr_r : s1_addr_r),
    .wdata (clr_r ? 8'd0 : res.wdata),
    .re    (in_acc),
    .raddr (addr0),
    .rdata (rd_data)
  );

  // output register: parts the pipeline from a stalled result sink
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_answer_r <= res.answer;
      out_status_r <= res.status;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.answer = out_answer_r;
  assign out_ch.status = out_status_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_work_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !s1_valid_r)
    else $error("operation in flight during clearing sweep");

  a_fwd_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> s1_valid_r)
    else $error("forwarding flag without an item in stage 1");

  a_result_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_adv))
    else $error("result beat appeared without a stage 1 advance");

  a_write_status: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && res.we) |-> (res.status == bca_pkg::ST_OK ||
                                res.status == bca_pkg::ST_OVF))
    else $error("cell write with range or mode error");

endmodule

// File: sv/bca_mem.sv
// bca_mem: byte-wide single-write, single-read synchronous memory.
// Read data registered, read-before-write on address collision. No package use.
module bca_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/bca_alu.sv
// bca_alu: modify step of the read-modify-write on one cell byte.
// Depends on bca_pkg (op/status codes, alu_res_t).
module bca_alu (
  input  logic [bca_pkg::OP_W-1:0]  op,
  input  logic [2:0]                sel,      // bit number; sel[0] picks nibble
  input  logic [bca_pkg::AMT_W-1:0] amount,
  input  logic [7:0]                data,
  input  bca_pkg::status_t          pre_st,   // mode / range verdict from issue
  output bca_pkg::alu_res_t         res
);

  logic [3:0] nib;
  logic [3:0] nib_inc;
  logic [3:0] nib_dec;
  logic [8:0] sum;
  logic [7:0] bit_mask;

  always_comb begin
    nib      = sel[0] ? data[7:4] : data[3:0];
    nib_inc  = nib + 4'd1;
    nib_dec  = nib - 4'd1;
    sum      = {1'b0, data} + {1'b0, amount};
    bit_mask = 8'd1 << sel;
  end

  always_comb begin
    res.answer = 1'b0;
    res.status = pre_st;
    res.we     = 1'b0;
    res.wdata  = data;
    if (pre_st == bca_pkg::ST_OK) begin
      unique case (bca_pkg::op_t'(op))
        bca_pkg::OP_SET: begin
          res.wdata  = data | bit_mask;
          res.we     = 1'b1;
          res.answer = 1'b1;
        end
        bca_pkg::OP_TEST: begin
          res.answer = |(data & bit_mask);
        end
        bca_pkg::OP_NINC: begin
          if (nib == bca_pkg::NIB_MAX) begin
            res.status = bca_pkg::ST_OVF;
          end else begin
            res.wdata  = sel[0] ? {nib_inc, data[3:0]} : {data[7:4], nib_inc};
            res.we     = 1'b1;
            res.answer = 1'b1;
          end
        end
        bca_pkg::OP_NDEC: begin
          if (nib != 4'd0) begin
            res.wdata  = sel[0] ? {nib_dec, data[3:0]} : {data[7:4], nib_dec};
            res.we     = 1'b1;
            res.answer = 1'b1;
          end
        end
        bca_pkg::OP_BADD: begin
          if (sum >= bca_pkg::BYTE_TOP) begin
            res.status = bca_pkg::ST_OVF;
          end
          res.wdata  = sum[7:0];
          res.we     = 1'b1;
          res.answer = 1'b1;
        end
        bca_pkg::OP_BSUB: begin
          if (data != 8'd0 && data >= amount) begin
            res.wdata  = data - amount;
            res.we     = 1'b1;
            res.answer = 1'b1;
          end
        end
        default: begin
          res.answer = 1'b0;  // unused op codes: no effect
        end
      endcase
    end
  end

endmodule
